// ===== rtl/assert_macros.svh =====
// Assertion helpers for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NIR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/nir_pkg.sv =====
`default_nettype none

package nir_pkg;

    // Field widths.
    localparam int IV_W    = 16;
    localparam int CODE_W  = 32;
    localparam int CMD_W   = 8;
    localparam int PHASE_W = 2;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Reset values of the timing windows, in microseconds.
    localparam logic [IV_W-1:0] LEADER_MIN_RST = 16'd13000;
    localparam logic [IV_W-1:0] LEADER_MAX_RST = 16'd14000;
    localparam logic [IV_W-1:0] BIT_MIN_RST    = 16'd900;
    localparam logic [IV_W-1:0] BIT_MAX_RST    = 16'd2600;
    localparam logic [IV_W-1:0] ONE_SPLIT_RST  = 16'd1750;

    // Last bit position of a frame.
    localparam logic [CNT_W-1:0] LAST_BIT = 6'd31;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_LEADER_MIN = 3'd0,
        REG_LEADER_MAX = 3'd1,
        REG_BIT_MIN    = 3'd2,
        REG_BIT_MAX    = 3'd3,
        REG_ONE_SPLIT  = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/nir_channels.sv =====
`default_nettype none

// Input channel: one edge or timeout event per transfer.
interface nir_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [nir_pkg::IV_W-1:0]     interval_us;

    modport source (output valid, output action, output interval_us, input ready);
    modport sink   (input valid, input action, input interval_us, output ready);
endinterface

// Output channel: one decode result per transfer.
interface nir_out_if;
    logic                          valid;
    logic                          ready;
    logic                          frame_done;
    logic [nir_pkg::CODE_W-1:0]    frame_code;
    logic [nir_pkg::CMD_W-1:0]     command_byte;
    logic                          rejected;
    logic [nir_pkg::PHASE_W-1:0]   phase;

    modport source (output valid, output frame_done, output frame_code,
                    output command_byte, output rejected, output phase, input ready);
    modport sink   (input valid, input frame_done, input frame_code,
                    input command_byte, input rejected, input phase, output ready);
endinterface

`default_nettype wire

// ===== rtl/nec_ir_frame_decoder.sv =====
`default_nettype none
// NEC infrared frame decoder.
// The input channel (i_in) carries one event per transfer: action 0 is a falling
// edge with the microseconds since the previous edge in interval_us, action 1 is
// a timeout of the interval timer. Every input transfer yields exactly one result
// transfer on o_out: frame_done with the 32-bit code and its command byte when the
// thirty-second data bit arrives, rejected when an interval falls outside its
// window, and the decode phase after the event.
// The decode windows are five 16-bit registers on the APB port at byte addresses
// 0, 4, 8, 12 and 16; they must be written only while no event is in flight, which
// the decoder itself does not enforce. An event accepted at one clock edge has its
// result at the output from the next cycle on. Throughput is one event per cycle
// while o_out.ready is high, set by the single output register holding the result.
// When the receiver stalls, the result stays in the output register and one more
// event is taken only in the cycle the waiting result is taken; otherwise i_in.ready
// stays low. A synchronous active-low reset returns the decoder to idle, clears
// the bit counter and code shifter, empties the output register and restores
// the default timing windows.

`include "assert_macros.svh"

module nec_ir_frame_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    nir_in_if.sink                             i_in,
    nir_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nir_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [nir_pkg::DATA_W-1:0]    pwdata,
    output logic      [nir_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    typedef enum logic [nir_pkg::PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_LEADER = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    // Timing window registers.
    logic [nir_pkg::IV_W-1:0]   r_leader_min;
    logic [nir_pkg::IV_W-1:0]   r_leader_max;
    logic [nir_pkg::IV_W-1:0]   r_bit_min;
    logic [nir_pkg::IV_W-1:0]   r_bit_max;
    logic [nir_pkg::IV_W-1:0]   r_one_split;

    // Decoder state.
    t_phase                      r_phase;
    logic [nir_pkg::CNT_W-1:0]   r_bit_count;
    logic [nir_pkg::CODE_W-1:0]  r_code_shift;

    // Output register.
    logic                        r_out_valid;
    logic                        r_out_done;
    logic [nir_pkg::CODE_W-1:0]  r_out_code;
    logic                        r_out_rej;
    t_phase                      r_out_phase;

    t_phase                      n_phase;
    logic [nir_pkg::CNT_W-1:0]   n_bit_count;
    logic [nir_pkg::CODE_W-1:0]  n_code_shift;
    logic                        n_done;
    logic                        n_rej;

    logic                        w_accept;
    logic                        w_cfg_write;
    logic [2:0]                  w_reg_idx;
    logic [nir_pkg::IV_W-1:0]    w_iv;
    logic                        w_leader_ok;
    logic                        w_bit_ok;
    logic                        w_bit_one;
    logic [4:0]                  w_bit_pos;
    logic [nir_pkg::CODE_W-1:0]  w_mask;

    // ---------------------------------------------------------------
    // Configuration port. Writes land at the access phase; reads are
    // combinational and pready is tied high.
    // ---------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_reg_idx   = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_min <= nir_pkg::LEADER_MIN_RST;
            r_leader_max <= nir_pkg::LEADER_MAX_RST;
            r_bit_min    <= nir_pkg::BIT_MIN_RST;
            r_bit_max    <= nir_pkg::BIT_MAX_RST;
            r_one_split  <= nir_pkg::ONE_SPLIT_RST;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                nir_pkg::REG_LEADER_MIN: r_leader_min <= pwdata[nir_pkg::IV_W-1:0];
                nir_pkg::REG_LEADER_MAX: r_leader_max <= pwdata[nir_pkg::IV_W-1:0];
                nir_pkg::REG_BIT_MIN:    r_bit_min    <= pwdata[nir_pkg::IV_W-1:0];
                nir_pkg::REG_BIT_MAX:    r_bit_max    <= pwdata[nir_pkg::IV_W-1:0];
                nir_pkg::REG_ONE_SPLIT:  r_one_split  <= pwdata[nir_pkg::IV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            nir_pkg::REG_LEADER_MIN: prdata = {16'd0, r_leader_min};
            nir_pkg::REG_LEADER_MAX: prdata = {16'd0, r_leader_max};
            nir_pkg::REG_BIT_MIN:    prdata = {16'd0, r_bit_min};
            nir_pkg::REG_BIT_MAX:    prdata = {16'd0, r_bit_max};
            nir_pkg::REG_ONE_SPLIT:  prdata = {16'd0, r_one_split};
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake. A new event is taken whenever the output register is
    // empty or its result leaves in this same cycle.
    // ---------------------------------------------------------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------
    // Event decode.
    // ---------------------------------------------------------------
    assign w_iv        = i_in.interval_us;
    assign w_leader_ok = (w_iv > r_leader_min) && (w_iv < r_leader_max);
    assign w_bit_ok    = (w_iv >= r_bit_min) && (w_iv <= r_bit_max);
    assign w_bit_one   = w_iv > r_one_split;
    // In the data phase the count is at most 31, so its low five bits
    // inverted give the bit position, first bit in bit 31.
    assign w_bit_pos   = ~r_bit_count[4:0];
    assign w_mask      = nir_pkg::CODE_W'(1) << w_bit_pos;

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_code_shift = r_code_shift;
        n_done       = 1'b0;
        n_rej        = 1'b0;
        if (i_in.action) begin
            // A timeout drops any frame in progress without a rejection.
            n_phase = PH_IDLE;
        end else begin
            case (r_phase)
                PH_LEADER: begin
                    if (w_leader_ok) begin
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = PH_IDLE;
                        n_rej   = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (!w_bit_ok) begin
                        // The bits gathered so far stay in the shifter.
                        n_phase = PH_IDLE;
                        n_rej   = 1'b1;
                    end else begin
                        n_code_shift = w_bit_one ? (r_code_shift | w_mask)
                                                 : (r_code_shift & ~w_mask);
                        n_bit_count  = r_bit_count + 6'd1;
                        if (r_bit_count == nir_pkg::LAST_BIT) begin
                            n_done  = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // Idle: the first edge opens a frame and its interval
                    // carries no meaning.
                    n_phase     = PH_LEADER;
                    n_bit_count = '0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State and output register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_code_shift <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_code_shift <= n_code_shift;
                r_out_valid  <= 1'b1;
                r_out_done   <= n_done;
                r_out_code   <= n_done ? n_code_shift : '0;
                r_out_rej    <= n_rej;
                r_out_phase  <= n_phase;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_done   = r_out_done;
    assign o_out.frame_code   = r_out_code;
    assign o_out.command_byte = r_out_code[15:8];
    assign o_out.rejected     = r_out_rej;
    assign o_out.phase        = r_out_phase;

    // ---------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------
    `NIR_ASSERT_SAME(a_data_count_range, i_clk, i_rst_n,
        r_phase == PH_DATA, r_bit_count <= nir_pkg::LAST_BIT)
    `NIR_ASSERT_NEXT(a_bit_advances, i_clk, i_rst_n,
        w_accept && !i_in.action && r_phase == PH_DATA && w_bit_ok,
        r_bit_count == $past(r_bit_count) + 6'd1)
    `NIR_ASSERT_SAME(a_code_only_when_done, i_clk, i_rst_n,
        r_out_valid && !r_out_done, r_out_code == '0)
    `NIR_ASSERT_SAME(a_done_goes_idle, i_clk, i_rst_n,
        r_out_valid && r_out_done, r_out_phase == PH_IDLE && !r_out_rej)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the NEC infrared frame decoder.
// Every edge or timeout event that the decoder accepts is run through a local
// copy of the decode state, and the result it must produce is queued. A separate
// process takes result transfers from the decoder and compares each one, field
// by field, with the oldest queued result.
module tb_top;

    // Event kinds on the input channel.
    localparam logic ACT_EDGE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Decode phases as reported in the result.
    localparam logic [nir_pkg::PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [nir_pkg::PHASE_W-1:0] PH_LEADER = 2'd1;
    localparam logic [nir_pkg::PHASE_W-1:0] PH_DATA   = 2'd2;

    localparam int FRAME_BITS = 32;
    // Start edge, leader interval and 32 data bits.
    localparam int FRAME_EVENTS = FRAME_BITS + 2;

    typedef struct packed {
        logic                          frame_done;
        logic [nir_pkg::CODE_W-1:0]    frame_code;
        logic [nir_pkg::CMD_W-1:0]     command_byte;
        logic                          rejected;
        logic [nir_pkg::PHASE_W-1:0]   phase;
    } t_decode_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [nir_pkg::ADDR_W-1:0]    paddr;
    logic [nir_pkg::DATA_W-1:0]    pwdata;
    wire  [nir_pkg::DATA_W-1:0]    prdata;
    wire                           pready;

    nir_in_if  in_ch ();
    nir_out_if out_ch ();

    nec_ir_frame_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the timing windows, kept in step with every register write.
    logic [nir_pkg::IV_W-1:0] win_leader_min = nir_pkg::LEADER_MIN_RST;
    logic [nir_pkg::IV_W-1:0] win_leader_max = nir_pkg::LEADER_MAX_RST;
    logic [nir_pkg::IV_W-1:0] win_bit_min    = nir_pkg::BIT_MIN_RST;
    logic [nir_pkg::IV_W-1:0] win_bit_max    = nir_pkg::BIT_MAX_RST;
    logic [nir_pkg::IV_W-1:0] win_one_split  = nir_pkg::ONE_SPLIT_RST;

    // Local copy of the decode state, as it stands after reset.
    logic [nir_pkg::PHASE_W-1:0] dec_phase = PH_IDLE;
    logic [nir_pkg::CNT_W-1:0]   dec_count = '0;
    logic [nir_pkg::CODE_W-1:0]  dec_code  = '0;

    // Results that accepted events must still produce, oldest first.
    t_decode_result pending_results[$];

    int fail_count       = 0;
    int events_sent      = 0;
    int frames_seen      = 0;
    int rejects_seen     = 0;
    int settings_applied = 0;

    // When set, the sender or the receiver runs without idle cycles.
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advances the decode state by one event and returns the result it must give.
    function automatic t_decode_result decode_event(input logic act,
                                                    input logic [nir_pkg::IV_W-1:0] iv);
        t_decode_result              r;
        logic [nir_pkg::CNT_W-1:0]   pos;
        r = '0;
        if (act == ACT_TIMEOUT) begin
            // A timeout drops any frame in progress without flagging it.
            dec_phase = PH_IDLE;
        end else if (dec_phase == PH_LEADER) begin
            // Both leader bounds are exclusive.
            if (iv > win_leader_min && iv < win_leader_max) begin
                dec_phase = PH_DATA;
            end else begin
                dec_phase = PH_IDLE;
                r.rejected = 1'b1;
            end
        end else if (dec_phase == PH_DATA) begin
            if (iv > win_bit_max || iv < win_bit_min) begin
                // The bits shifted in so far stay in the shifter.
                dec_phase = PH_IDLE;
                r.rejected = 1'b1;
            end else begin
                pos = nir_pkg::LAST_BIT - dec_count;
                dec_code[pos[4:0]] = (iv > win_one_split);
                dec_count = dec_count + 1'b1;
                if (dec_count >= FRAME_BITS) begin
                    r.frame_done   = 1'b1;
                    r.frame_code   = dec_code;
                    r.command_byte = dec_code[15:8];
                    dec_phase      = PH_IDLE;
                end
            end
        end else begin
            // An edge while idle opens a frame; its interval carries no meaning.
            dec_phase = PH_LEADER;
            dec_count = '0;
        end
        r.phase = dec_phase;
        return r;
    endfunction

    // Offers one event after a random gap and holds it until the decoder takes it.
    // Valid is left high so that a following event without a gap keeps it asserted.
    task automatic send_event(input logic act, input logic [nir_pkg::IV_W-1:0] iv);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(10, 0);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.interval_us <= iv;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_results.push_back(decode_event(act, iv));
        events_sent++;
    endtask

    // Lowers valid and waits until every queued result has been taken.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // The extra wait lets any stray result transfer show up.
        repeat (4) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // access edge. The bus is left selected so that writes can follow back to back.
    task automatic write_reg(input nir_pkg::t_reg_idx idx,
                             input logic [nir_pkg::IV_W-1:0] value);
        logic [15:0] junk;
        junk = 16'($urandom_range(65535, 0));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Upper bits are noise: the registers keep only the low 16 bits.
        pwdata  <= {junk, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            nir_pkg::REG_LEADER_MIN: win_leader_min = value;
            nir_pkg::REG_LEADER_MAX: win_leader_max = value;
            nir_pkg::REG_BIT_MIN:    win_bit_min    = value;
            nir_pkg::REG_BIT_MAX:    win_bit_max    = value;
            nir_pkg::REG_ONE_SPLIT:  win_one_split  = value;
            default: ;
        endcase
    endtask

    // Programs all five windows. Only called once the decoder has gone quiet.
    task automatic apply_windows(input logic [nir_pkg::IV_W-1:0] lmin,
                                 input logic [nir_pkg::IV_W-1:0] lmax,
                                 input logic [nir_pkg::IV_W-1:0] bmin,
                                 input logic [nir_pkg::IV_W-1:0] bmax,
                                 input logic [nir_pkg::IV_W-1:0] split);
        write_reg(nir_pkg::REG_LEADER_MIN, lmin);
        write_reg(nir_pkg::REG_LEADER_MAX, lmax);
        write_reg(nir_pkg::REG_BIT_MIN, bmin);
        write_reg(nir_pkg::REG_BIT_MAX, bmax);
        write_reg(nir_pkg::REG_ONE_SPLIT, split);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        settings_applied++;
    endtask

    // Sends one frame that fits the current windows where they leave room. When
    // break_at names an event of the frame, that event is replaced by a timeout or
    // by an interval outside its window and the frame stops there.
    task automatic send_frame(input logic [nir_pkg::CODE_W-1:0] code_word, input int break_at);
        int lo;
        int hi;
        int v;
        for (int idx = 0; idx < FRAME_EVENTS; idx++) begin
            if (idx == break_at) begin
                if (idx == 0 || $urandom_range(1, 0) == 0) begin
                    send_event(ACT_TIMEOUT, nir_pkg::IV_W'($urandom_range(65535, 0)));
                end else if (idx == 1) begin
                    if ($urandom_range(1, 0) == 0)
                        v = $urandom_range(win_leader_min, 0);
                    else
                        v = $urandom_range(65535, win_leader_max);
                    send_event(ACT_EDGE, nir_pkg::IV_W'(v));
                end else if (win_bit_min > 0 &&
                             ($urandom_range(1, 0) == 0 || win_bit_max == 16'hFFFF)) begin
                    send_event(ACT_EDGE, nir_pkg::IV_W'($urandom_range(win_bit_min - 1, 0)));
                end else if (win_bit_max != 16'hFFFF) begin
                    send_event(ACT_EDGE,
                               nir_pkg::IV_W'($urandom_range(65535, win_bit_max + 1)));
                end else begin
                    // The bit window covers every value, so only a timeout can break it.
                    send_event(ACT_TIMEOUT, nir_pkg::IV_W'($urandom_range(65535, 0)));
                end
                return;
            end
            if (idx == 0) begin
                send_event(ACT_EDGE, nir_pkg::IV_W'($urandom_range(65535, 0)));
            end else begin
                if (idx == 1) begin
                    lo = int'(win_leader_min) + 1;
                    hi = int'(win_leader_max) - 1;
                end else if (code_word[FRAME_EVENTS - 1 - idx]) begin
                    lo = (int'(win_one_split) + 1 > int'(win_bit_min)) ?
                         int'(win_one_split) + 1 : int'(win_bit_min);
                    hi = int'(win_bit_max);
                end else begin
                    lo = int'(win_bit_min);
                    hi = (win_one_split < win_bit_max) ? int'(win_one_split)
                                                       : int'(win_bit_max);
                end
                // Fall back to the whole bit window, then to anything at all,
                // when the windows leave no room for the wanted value.
                if (lo > hi && idx > 1) begin
                    lo = int'(win_bit_min);
                    hi = int'(win_bit_max);
                end
                if (lo > hi)
                    v = $urandom_range(65535, 0);
                else
                    v = $urandom_range(hi, lo);
                send_event(ACT_EDGE, nir_pkg::IV_W'(v));
            end
        end
    endtask

    // Boundaries of the default windows, every phase hit by a timeout, and
    // intervals at both ends of the field.
    task automatic test_reset_windows();
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        send_event(ACT_TIMEOUT, 16'hFFFF);   // timeout while idle
        send_event(ACT_EDGE, 16'd0);         // start edge, interval ignored
        send_event(ACT_EDGE, 16'd13000);     // leader on the lower bound: rejected
        send_event(ACT_EDGE, 16'hFFFF);      // start edge with the largest interval
        send_event(ACT_EDGE, 16'd14000);     // leader on the upper bound: rejected
        send_event(ACT_EDGE, 16'd0);
        send_event(ACT_EDGE, 16'd13001);     // shortest accepted leader
        send_event(ACT_TIMEOUT, 16'd0);      // timeout during the data bits
        send_event(ACT_EDGE, 16'd5);
        send_event(ACT_EDGE, 16'd13999);     // longest accepted leader
        send_event(ACT_EDGE, 16'd900);       // shortest bit, a zero
        send_event(ACT_EDGE, 16'd1750);      // on the split, still a zero
        send_event(ACT_EDGE, 16'd1751);      // just above the split, a one
        send_event(ACT_EDGE, 16'd2600);      // longest bit, a one
        send_event(ACT_EDGE, 16'd899);       // too short: rejected
        send_event(ACT_EDGE, 16'd1);
        send_event(ACT_EDGE, 16'd13500);
        send_event(ACT_EDGE, 16'd2601);      // too long: rejected
        send_event(ACT_EDGE, 16'd1);
        send_event(ACT_TIMEOUT, 16'd1234);   // timeout while waiting for the leader
        send_event(ACT_EDGE, 16'd1);
        send_event(ACT_EDGE, 16'd13500);
        send_event(ACT_EDGE, 16'd0);         // zero interval as a bit
        send_event(ACT_EDGE, 16'd1);
        send_event(ACT_EDGE, 16'd13500);
        send_event(ACT_EDGE, 16'hFFFF);      // largest interval as a bit
        wait_for_results();
    endtask

    // Complete frames with default windows, some of them back to back, which
    // also starts a new frame right after a finished one.
    task automatic test_full_frames();
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        send_frame(32'h0000_0000, -1);
        send_frame(32'hFFFF_FFFF, -1);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        send_frame(32'hA55A_00FF, -1);
        send_frame(32'h00FF_FF00, -1);
        send_frame($urandom, -1);
        // Broken on the very last bit, then a clean frame over the leftover bits.
        send_frame($urandom, FRAME_EVENTS - 1);
        send_frame($urandom, -1);
        wait_for_results();
    endtask

    // Mostly well-formed frames with random content; some are broken at a
    // random point, and short runs of noise fall between them.
    task automatic test_random_traffic(input int n_items);
        int stop_at;
        int v;
        stop_at = events_sent + n_items;
        while (events_sent < stop_at) begin
            tx_burst = ($urandom_range(3, 0) == 0);
            rx_burst = ($urandom_range(3, 0) == 0);
            if ($urandom_range(9, 0) < 7) begin
                if (dec_phase != PH_IDLE)
                    send_event(ACT_TIMEOUT, nir_pkg::IV_W'($urandom_range(65535, 0)));
                send_frame($urandom, ($urandom_range(3, 0) == 0) ?
                           int'($urandom_range(FRAME_EVENTS - 1, 0)) : -1);
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    // Noise clusters around the window bounds and the field ends.
                    case ($urandom_range(6, 0))
                        0: v = $urandom_range(65535, 0);
                        1: v = int'(win_leader_min) + int'($urandom_range(4, 0)) - 2;
                        2: v = int'(win_leader_max) + int'($urandom_range(4, 0)) - 2;
                        3: v = int'(win_bit_min) + int'($urandom_range(4, 0)) - 2;
                        4: v = int'(win_bit_max) + int'($urandom_range(4, 0)) - 2;
                        5: v = int'(win_one_split) + int'($urandom_range(4, 0)) - 2;
                        default: v = ($urandom_range(1, 0) == 0) ? 0 : 65535;
                    endcase
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    send_event(($urandom_range(4, 0) == 0) ? ACT_TIMEOUT : ACT_EDGE,
                               nir_pkg::IV_W'(v));
                end
            end
        end
        wait_for_results();
    endtask

    // Several window settings, the extremes among them, each with random traffic.
    task automatic test_window_settings();
        logic [nir_pkg::IV_W-1:0] lmin;
        logic [nir_pkg::IV_W-1:0] lmax;
        logic [nir_pkg::IV_W-1:0] bmin;
        logic [nir_pkg::IV_W-1:0] bmax;
        // Widest windows; only a zero interval decodes as a zero bit.
        apply_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        test_random_traffic(20);
        // Bit window holds the largest value only, and the split makes it a zero.
        apply_windows(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(20);
        // Both windows empty: every leader and every bit is rejected.
        apply_windows(16'hFFFF, 16'd0, 16'd3000, 16'd1000, 16'd2000);
        test_random_traffic(20);
        // Single-value windows; every accepted bit is a one.
        apply_windows(16'd100, 16'd102, 16'd1200, 16'd1200, 16'd1199);
        test_random_traffic(20);
        lmin = nir_pkg::IV_W'($urandom_range(60000, 0));
        lmax = lmin + nir_pkg::IV_W'($urandom_range(5000, 2));
        bmin = nir_pkg::IV_W'($urandom_range(30000, 0));
        bmax = bmin + nir_pkg::IV_W'($urandom_range(30000, 0));
        apply_windows(lmin, lmax, bmin, bmax, nir_pkg::IV_W'($urandom_range(bmax, bmin)));
        test_random_traffic(20);
        apply_windows(nir_pkg::LEADER_MIN_RST, nir_pkg::LEADER_MAX_RST,
                      nir_pkg::BIT_MIN_RST, nir_pkg::BIT_MAX_RST,
                      nir_pkg::ONE_SPLIT_RST);
        test_random_traffic(20);
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            fail_count++;
        end
    endtask

    // Result side: stalls for a random number of cycles before each transfer,
    // then checks the transfer against the oldest queued result.
    initial begin : result_sink
        int stall;
        t_decode_result want;
        out_ch.ready = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(10, 0);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $error("result transfer with no event waiting for it");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("frame_done", want.frame_done, out_ch.frame_done);
                check_field("frame_code", want.frame_code, out_ch.frame_code);
                check_field("command_byte", want.command_byte, out_ch.command_byte);
                check_field("rejected", want.rejected, out_ch.rejected);
                check_field("phase", want.phase, out_ch.phase);
                if (want.frame_done) frames_seen++;
                if (want.rejected) rejects_seen++;
            end
        end
    end

    // Event side and test sequence.
    initial begin : stimulus
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_EDGE;
        in_ch.interval_us = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_windows();
        test_full_frames();
        test_random_traffic(40);
        test_window_settings();

        $display("Run covered %0d events, %0d decoded frames and %0d rejected intervals.",
                 events_sent, frames_seen, rejects_seen);
        $display("Timing windows were reprogrammed %0d times, empty windows included.",
                 settings_applied);
        if (fail_count == 0) begin
            $display("** nec_ir_frame_decoder: PASSED **");
        end else begin
            $display("** nec_ir_frame_decoder: FAILED **");
        end
        $finish;
    end

    // Far beyond the slowest correct run, which stays well under half a millisecond.
    initial begin : watchdog
        #5_000_000;
        $display("Run did not finish in time, %0d results still pending.",
                 pending_results.size());
        $display("** nec_ir_frame_decoder: FAILED **");
        $finish;
    end

endmodule
